@@ rtl/core/rvdec_pkg.sv @@
// Shared types, encodings and lookup functions for the RV32IM decoder.
package rvdec_pkg;

  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SR   = 3'd5;

  localparam logic [31:0] WORD_ECALL      = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK     = 32'h0010_0073;
  localparam logic [31:0] WORD_PAUSE      = 32'h0100_000F;
  localparam logic [31:0] FENCE_ZERO_MASK = 32'hF00F_FFF0;

  typedef enum logic [5:0] {
    MN_INVALID = 6'd0,
    MN_ADDI    = 6'd1,
    MN_SLTI    = 6'd2,
    MN_SLTIU   = 6'd3,
    MN_XORI    = 6'd4,
    MN_ORI     = 6'd5,
    MN_ANDI    = 6'd6,
    MN_SLLI    = 6'd7,
    MN_SRLI    = 6'd8,
    MN_SRAI    = 6'd9,
    MN_ADD     = 6'd10,
    MN_MUL     = 6'd11,
    MN_SUB     = 6'd12,
    MN_SLL     = 6'd13,
    MN_MULH    = 6'd14,
    MN_SLT     = 6'd15,
    MN_MULHSU  = 6'd16,
    MN_SLTU    = 6'd17,
    MN_MULHU   = 6'd18,
    MN_XOR     = 6'd19,
    MN_DIV     = 6'd20,
    MN_SRL     = 6'd21,
    MN_DIVU    = 6'd22,
    MN_SRA     = 6'd23,
    MN_OR      = 6'd24,
    MN_REM     = 6'd25,
    MN_AND     = 6'd26,
    MN_REMU    = 6'd27,
    MN_JAL     = 6'd28,
    MN_JALR    = 6'd29,
    MN_LUI     = 6'd30,
    MN_AUIPC   = 6'd31,
    MN_BEQ     = 6'd32,
    MN_BNE     = 6'd33,
    MN_BLT     = 6'd34,
    MN_BGE     = 6'd35,
    MN_BLTU    = 6'd36,
    MN_BGEU    = 6'd37,
    MN_LB      = 6'd38,
    MN_LH      = 6'd39,
    MN_LW      = 6'd40,
    MN_LBU     = 6'd41,
    MN_LHU     = 6'd42,
    MN_SB      = 6'd43,
    MN_SH      = 6'd44,
    MN_SW      = 6'd45,
    MN_ECALL   = 6'd46,
    MN_EBREAK  = 6'd47,
    MN_PAUSE   = 6'd48,
    MN_FENCE   = 6'd49
  } mnemonic_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_addr;
  } instr_t;

  typedef struct packed {
    logic               is_invalid;
    mnemonic_t          mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_addr;
    logic [3:0]         fence_pred;
    logic [3:0]         fence_succ;
  } decoded_t;

  function automatic mnemonic_t opimm_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_ADDI;
      3'd1:    mn = MN_SLLI;
      3'd2:    mn = MN_SLTI;
      3'd3:    mn = MN_SLTIU;
      3'd4:    mn = MN_XORI;
      3'd5:    mn = MN_INVALID;
      3'd6:    mn = MN_ORI;
      default: mn = MN_ANDI;
    endcase
    return mn;
  endfunction

  function automatic mnemonic_t base_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_ADD;
      3'd1:    mn = MN_SLL;
      3'd2:    mn = MN_SLT;
      3'd3:    mn = MN_SLTU;
      3'd4:    mn = MN_XOR;
      3'd5:    mn = MN_SRL;
      3'd6:    mn = MN_OR;
      default: mn = MN_AND;
    endcase
    return mn;
  endfunction

  function automatic mnemonic_t muldiv_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_MUL;
      3'd1:    mn = MN_MULH;
      3'd2:    mn = MN_MULHSU;
      3'd3:    mn = MN_MULHU;
      3'd4:    mn = MN_DIV;
      3'd5:    mn = MN_DIVU;
      3'd6:    mn = MN_REM;
      default: mn = MN_REMU;
    endcase
    return mn;
  endfunction

  function automatic mnemonic_t branch_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_BEQ;
      3'd1:    mn = MN_BNE;
      3'd4:    mn = MN_BLT;
      3'd5:    mn = MN_BGE;
      3'd6:    mn = MN_BLTU;
      3'd7:    mn = MN_BGEU;
      default: mn = MN_INVALID;
    endcase
    return mn;
  endfunction

  function automatic mnemonic_t load_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_LB;
      3'd1:    mn = MN_LH;
      3'd2:    mn = MN_LW;
      3'd4:    mn = MN_LBU;
      3'd5:    mn = MN_LHU;
      default: mn = MN_INVALID;
    endcase
    return mn;
  endfunction

  function automatic mnemonic_t store_mn(input logic [2:0] f3);
    mnemonic_t mn;
    unique case (f3)
      3'd0:    mn = MN_SB;
      3'd1:    mn = MN_SH;
      3'd2:    mn = MN_SW;
      default: mn = MN_INVALID;
    endcase
    return mn;
  endfunction

endpackage

@@ rtl/core/rv32im_instruction_decoder.sv @@
// Top level of the RV32IM instruction decoder.
// Decodes one 32-bit RV32IM instruction word and its address per item into a
// mnemonic code (0 when invalid), the rd/rs1/rs2 fields, the decoded
// immediate, the branch or JAL target and the fence masks. An item passes an
// input register and then a result register, which presents the result;
// with no stall downstream one item is taken every cycle. The combinational
// decode and 32-bit target adder lie between the two registers. A stalled
// result holds while an empty input register still takes a new item, so the
// block takes input until both stages are full.
module rv32im_instruction_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  instr_valid,
  output logic                  instr_stall,
  input  rvdec_pkg::instr_t     instr,
  output logic                  dec_valid,
  input  logic                  dec_stall,
  output rvdec_pkg::decoded_t   dec
);

  logic                 fetch_valid;
  rvdec_pkg::instr_t    fetch_item;
  rvdec_pkg::decoded_t  decoded;
  logic                 out_advance;
  logic                 in_advance;

  assign in_advance  = !fetch_valid || out_advance;
  assign instr_stall = !in_advance;

  rvdec_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .valid      (instr_valid),
    .item       (instr),
    .advance    (in_advance),
    .held_valid (fetch_valid),
    .held_item  (fetch_item)
  );

  rvdec_decode u_decode (
    .item   (fetch_item),
    .result (decoded)
  );

  rvdec_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fetch_valid),
    .in_item  (decoded),
    .stall    (dec_stall),
    .advance  (out_advance),
    .valid    (dec_valid),
    .item     (dec)
  );

endmodule

@@ rtl/core/rvdec_in_reg.sv @@
// Input register stage holding one instruction item for decode.
module rvdec_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  rvdec_pkg::instr_t   item,
  input  logic                advance,
  output logic                held_valid,
  output rvdec_pkg::instr_t   held_item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      held_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid) begin
      held_item <= item;
    end
  end

endmodule

@@ rtl/core/rvdec_decode.sv @@
// Combinational RV32IM field, immediate and mnemonic decode.
module rvdec_decode (
  input  rvdec_pkg::instr_t   item,
  output rvdec_pkg::decoded_t result
);

  logic [31:0]          w;
  logic [6:0]           opcode;
  logic [2:0]           f3;
  logic [6:0]           f7;
  logic [31:0]          imm_i;
  logic [31:0]          imm_s;
  logic [31:0]          imm_b;
  logic [31:0]          imm_j;
  logic [31:0]          imm_u;
  logic [31:0]          shamt;
  rvdec_pkg::mnemonic_t mn;
  logic [31:0]          imm;
  logic                 has_target;
  logic [3:0]           pred;
  logic [3:0]           succ;
  logic [31:0]          target_sum;

  assign w      = item.instr_word;
  assign opcode = w[6:0];
  assign f3     = w[14:12];
  assign f7     = w[31:25];
  assign imm_i  = {{20{w[31]}}, w[31:20]};
  assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u  = {12'b0, w[31:12]};
  assign shamt  = {27'b0, w[24:20]};

  always_comb begin
    mn         = rvdec_pkg::MN_INVALID;
    imm        = '0;
    has_target = 1'b0;
    pred       = '0;
    succ       = '0;
    unique case (opcode)
      rvdec_pkg::OPC_OP_IMM: begin
        imm = shamt;
        if (f3 == rvdec_pkg::F3_SLL) begin
          if (f7 == rvdec_pkg::F7_BASE) begin
            mn = rvdec_pkg::MN_SLLI;
          end
        end else if (f3 == rvdec_pkg::F3_SR) begin
          if (f7 == rvdec_pkg::F7_BASE) begin
            mn = rvdec_pkg::MN_SRLI;
          end else if (f7 == rvdec_pkg::F7_ALT) begin
            mn = rvdec_pkg::MN_SRAI;
          end
        end else begin
          mn  = rvdec_pkg::opimm_mn(f3);
          imm = imm_i;
        end
      end
      rvdec_pkg::OPC_OP: begin
        if (f7 == rvdec_pkg::F7_BASE) begin
          mn = rvdec_pkg::base_mn(f3);
        end else if (f7 == rvdec_pkg::F7_MULDIV) begin
          mn = rvdec_pkg::muldiv_mn(f3);
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ZERO) begin
          mn = rvdec_pkg::MN_SUB;
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_SR) begin
          mn = rvdec_pkg::MN_SRA;
        end
      end
      rvdec_pkg::OPC_JAL: begin
        mn         = rvdec_pkg::MN_JAL;
        imm        = imm_j;
        has_target = 1'b1;
      end
      rvdec_pkg::OPC_JALR: begin
        if (f3 == rvdec_pkg::F3_ZERO) begin
          mn = rvdec_pkg::MN_JALR;
        end
        imm = imm_i;
      end
      rvdec_pkg::OPC_LUI: begin
        mn  = rvdec_pkg::MN_LUI;
        imm = imm_u;
      end
      rvdec_pkg::OPC_AUIPC: begin
        mn  = rvdec_pkg::MN_AUIPC;
        imm = imm_u;
      end
      rvdec_pkg::OPC_BRANCH: begin
        mn         = rvdec_pkg::branch_mn(f3);
        imm        = imm_b;
        has_target = 1'b1;
      end
      rvdec_pkg::OPC_LOAD: begin
        mn  = rvdec_pkg::load_mn(f3);
        imm = imm_i;
      end
      rvdec_pkg::OPC_STORE: begin
        mn  = rvdec_pkg::store_mn(f3);
        imm = imm_s;
      end
      rvdec_pkg::OPC_SYSTEM: begin
        if (w == rvdec_pkg::WORD_ECALL) begin
          mn = rvdec_pkg::MN_ECALL;
        end else if (w == rvdec_pkg::WORD_EBREAK) begin
          mn = rvdec_pkg::MN_EBREAK;
        end
      end
      rvdec_pkg::OPC_FENCE: begin
        if (f3 == rvdec_pkg::F3_ZERO) begin
          if (w == rvdec_pkg::WORD_PAUSE) begin
            mn = rvdec_pkg::MN_PAUSE;
          end else if ((w & rvdec_pkg::FENCE_ZERO_MASK) == 32'h0) begin
            mn   = rvdec_pkg::MN_FENCE;
            pred = w[27:24];
            succ = w[23:20];
          end
        end
      end
      default: begin
        mn = rvdec_pkg::MN_INVALID;
      end
    endcase
  end

  assign target_sum = item.instr_addr + imm;

  always_comb begin
    result.is_invalid  = (mn == rvdec_pkg::MN_INVALID);
    result.mnemonic    = mn;
    result.dest_reg    = w[11:7];
    result.src1_reg    = w[19:15];
    result.src2_reg    = w[24:20];
    result.immediate   = '0;
    result.target_addr = '0;
    result.fence_pred  = '0;
    result.fence_succ  = '0;
    if (mn != rvdec_pkg::MN_INVALID) begin
      result.immediate  = imm;
      result.fence_pred = pred;
      result.fence_succ = succ;
      if (has_target) begin
        result.target_addr = target_sum;
      end
    end
  end

endmodule

@@ rtl/core/rvdec_out_reg.sv @@
// Result register stage presenting one decoded item downstream.
module rvdec_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  rvdec_pkg::decoded_t   in_item,
  input  logic                  stall,
  output logic                  advance,
  output logic                  valid,
  output rvdec_pkg::decoded_t   item
);

  assign advance = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item <= in_item;
    end
  end

endmodule
